>>> rtl/cbh_pkg.sv
// shared constants, types and weight function for the bezier hit test
package cbh_pkg;

    localparam int CURVE_STEPS = 20;
    localparam int COORD_BITS  = 16;
    localparam int TOL_BITS    = 8;
    localparam logic [TOL_BITS-1:0] TOL_RESET = TOL_BITS'(5);

    localparam int NUM_PTS   = CURVE_STEPS + 1;
    localparam int NUM_CHORD = CURVE_STEPS + 1;
    localparam longint DIV   = longint'(CURVE_STEPS) * CURVE_STEPS * CURVE_STEPS;
    localparam int DIV_LOG   = $clog2(DIV);
    localparam int MAG_BITS  = COORD_BITS + DIV_LOG;
    localparam int SUM_BITS  = MAG_BITS + 1;
    localparam int REC_SHIFT = MAG_BITS + DIV_LOG;
    localparam int REC_BITS  = REC_SHIFT - DIV_LOG + 1;
    localparam longint REC_MULT = ((longint'(1) <<< REC_SHIFT) + DIV - 1) / DIV;
    localparam int PROD_BITS = MAG_BITS + REC_BITS;

    localparam int DIFF_BITS = COORD_BITS + 2;
    localparam int MUL_BITS  = 2 * DIFF_BITS;
    localparam int CROSS_BITS = MUL_BITS + 1;
    localparam int TD_BITS   = TOL_BITS + DIFF_BITS;

    typedef struct packed {
        logic signed [COORD_BITS-1:0] qx;
        logic signed [COORD_BITS-1:0] qy;
        logic [TOL_BITS-1:0]          tol;
    } ctx_t;

    // bernstein weight of control point j at step k, scaled by CURVE_STEPS cubed
    function automatic longint bern(input int k, input int j);
        longint h;
        longint kk;
        longint w;
        h  = longint'(CURVE_STEPS - k);
        kk = longint'(k);
        unique case (j)
            0:       w = h * h * h;
            1:       w = 3 * kk * h * h;
            2:       w = 3 * kk * kk * h;
            default: w = kk * kk * kk;
        endcase
        return w;
    endfunction

endpackage

>>> rtl/cubic_bezier_hit_test_top.sv
// cubic bezier point hit test, fully pipelined
// Accepts one curve and query request per cycle unless the output stalls, and returns one
// hit flag per request, in order, via these registers: an input register, the bernstein
// sums, the reciprocal multiply that divides by the step count cubed, the curve point
// register, chord setup over all chords in parallel lanes, the cross product multiplies,
// and the output register that holds the or of all chord tests. An output stall holds
// the whole pipeline; the user must write hit_tolerance only while idle (not enforced).
module cubic_bezier_hit_test_top (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 cfg_wr_en,
    input  logic [cbh_pkg::TOL_BITS-1:0]         cfg_wr_data,
    input  logic                                 in_valid,
    output logic                                 in_ready,
    input  logic signed [cbh_pkg::COORD_BITS-1:0] start_x,
    input  logic signed [cbh_pkg::COORD_BITS-1:0] start_y,
    input  logic signed [cbh_pkg::COORD_BITS-1:0] ctrl1_x,
    input  logic signed [cbh_pkg::COORD_BITS-1:0] ctrl1_y,
    input  logic signed [cbh_pkg::COORD_BITS-1:0] ctrl2_x,
    input  logic signed [cbh_pkg::COORD_BITS-1:0] ctrl2_y,
    input  logic signed [cbh_pkg::COORD_BITS-1:0] end_x,
    input  logic signed [cbh_pkg::COORD_BITS-1:0] end_y,
    input  logic signed [cbh_pkg::COORD_BITS-1:0] query_x,
    input  logic signed [cbh_pkg::COORD_BITS-1:0] query_y,
    output logic                                 out_valid,
    input  logic                                 out_ready,
    output logic                                 hit
);

    localparam int CB  = cbh_pkg::COORD_BITS;
    localparam int NP  = cbh_pkg::NUM_PTS;
    localparam int NC  = cbh_pkg::NUM_CHORD;
    localparam int SB  = cbh_pkg::SUM_BITS;
    localparam int MB  = cbh_pkg::MAG_BITS;
    localparam int RB  = cbh_pkg::REC_BITS;
    localparam int PB  = cbh_pkg::PROD_BITS;
    localparam int DB  = cbh_pkg::DIFF_BITS;
    localparam int XB  = cbh_pkg::MUL_BITS;
    localparam int CRB = cbh_pkg::CROSS_BITS;
    localparam int TDB = cbh_pkg::TD_BITS;
    localparam int TB  = cbh_pkg::TOL_BITS;
    localparam logic [RB-1:0] REC_M = RB'(cbh_pkg::REC_MULT);

    logic [TB-1:0] tol_reg;
    logic [5:0]    vld_reg;
    logic [5:0]    vld_next;
    logic          out_valid_reg;
    logic          hit_reg;
    logic          hit_next;
    logic          en;

    cbh_pkg::ctx_t ctx_reg [0:4];

    logic signed [CB-1:0] a_pt_reg [0:3][0:1];
    logic [MB-1:0]        b_mag_reg [0:NP-1][0:1];
    logic                 b_neg_reg [0:NP-1][0:1];
    logic [PB-1:0]        c_prod_reg [0:NP-1][0:1];
    logic                 c_neg_reg [0:NP-1][0:1];
    logic signed [CB-1:0] d_pt_reg [0:NP-1][0:1];

    logic                 e_box_reg  [0:NC-1];
    logic                 e_vert_reg [0:NC-1];
    logic                 e_vres_reg [0:NC-1];
    logic signed [DB-1:0] e_dx_reg   [0:NC-1];
    logic signed [DB-1:0] e_dy_reg   [0:NC-1];
    logic signed [DB-1:0] e_rx_reg   [0:NC-1];
    logic signed [DB-1:0] e_ry_reg   [0:NC-1];

    logic                 f_box_reg   [0:NC-1];
    logic                 f_vert_reg  [0:NC-1];
    logic                 f_vres_reg  [0:NC-1];
    logic                 f_steep_reg [0:NC-1];
    logic signed [XB-1:0] f_p1_reg    [0:NC-1];
    logic signed [XB-1:0] f_p2_reg    [0:NC-1];
    logic [TDB-1:0]       f_tdy_reg   [0:NC-1];
    logic [TDB-1:0]       f_tdx_reg   [0:NC-1];

    logic [NC-1:0] chord_hit;

    assign en        = !out_valid_reg || out_ready;
    assign in_ready  = en;
    assign out_valid = out_valid_reg;
    assign hit       = hit_reg;
    assign vld_next  = {vld_reg[4:0], in_valid};
    assign hit_next  = |chord_hit;

    // control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tol_reg       <= cbh_pkg::TOL_RESET;
            vld_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                tol_reg <= cfg_wr_data;
            end
            if (en)
            begin
                vld_reg       <= vld_next;
                out_valid_reg <= vld_reg[5];
            end
        end
    end

    // input stage and context
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            a_pt_reg[0][0] <= start_x;
            a_pt_reg[0][1] <= start_y;
            a_pt_reg[1][0] <= ctrl1_x;
            a_pt_reg[1][1] <= ctrl1_y;
            a_pt_reg[2][0] <= ctrl2_x;
            a_pt_reg[2][1] <= ctrl2_y;
            a_pt_reg[3][0] <= end_x;
            a_pt_reg[3][1] <= end_y;
            ctx_reg[0].qx  <= query_x;
            ctx_reg[0].qy  <= query_y;
            ctx_reg[0].tol <= tol_reg;
            for (int s = 1; s < 5; s++)
            begin
                ctx_reg[s] <= ctx_reg[s-1];
            end
            hit_reg <= hit_next;
        end
    end

    // curve points: bernstein sum, reciprocal multiply, truncate toward zero
    for (genvar k = 0; k < NP; k++)
    begin : g_pt
        localparam logic signed [SB-1:0] W0 = SB'(cbh_pkg::bern(k, 0));
        localparam logic signed [SB-1:0] W1 = SB'(cbh_pkg::bern(k, 1));
        localparam logic signed [SB-1:0] W2 = SB'(cbh_pkg::bern(k, 2));
        localparam logic signed [SB-1:0] W3 = SB'(cbh_pkg::bern(k, 3));
        for (genvar ax = 0; ax < 2; ax++)
        begin : g_ax
            logic signed [SB-1:0] sum;
            logic [SB-1:0]        mag;
            logic [CB-1:0]        quo;

            assign sum = W0 * SB'(a_pt_reg[0][ax]) + W1 * SB'(a_pt_reg[1][ax])
                       + W2 * SB'(a_pt_reg[2][ax]) + W3 * SB'(a_pt_reg[3][ax]);
            assign mag = sum[SB-1] ? (-sum) : sum;
            assign quo = c_prod_reg[k][ax][cbh_pkg::REC_SHIFT +: CB];

            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    b_mag_reg[k][ax]  <= mag[MB-1:0];
                    b_neg_reg[k][ax]  <= sum[SB-1];
                    c_prod_reg[k][ax] <= PB'(b_mag_reg[k][ax]) * PB'(REC_M);
                    c_neg_reg[k][ax]  <= b_neg_reg[k][ax];
                    d_pt_reg[k][ax]   <= c_neg_reg[k][ax] ? $signed(-quo) : $signed(quo);
                end
            end
        end
    end

    // chord lanes: the first chord joins the start point to itself
    for (genvar i = 0; i < NC; i++)
    begin : g_ch
        localparam int IA = (i == 0) ? 0 : i - 1;
        logic signed [DB-1:0] x0, y0, x1, y1, qx, qy, tl;
        logic signed [DB-1:0] lox, hix, loy, hiy;
        logic signed [DB-1:0] sx0, sy0, sx1, sy1, dx, dy;
        logic                 swap;
        logic [DB-1:0]        ady;
        logic signed [CRB-1:0] cr;
        logic [CRB-1:0]        acr;

        assign x0 = DB'(d_pt_reg[IA][0]);
        assign y0 = DB'(d_pt_reg[IA][1]);
        assign x1 = DB'(d_pt_reg[i][0]);
        assign y1 = DB'(d_pt_reg[i][1]);
        assign qx = DB'(ctx_reg[3].qx);
        assign qy = DB'(ctx_reg[3].qy);
        assign tl = $signed(DB'(ctx_reg[3].tol));
        assign lox = (x0 < x1) ? x0 : x1;
        assign hix = (x0 < x1) ? x1 : x0;
        assign loy = (y0 < y1) ? y0 : y1;
        assign hiy = (y0 < y1) ? y1 : y0;
        assign swap = (x1 <= x0);
        assign sx0 = swap ? x1 : x0;
        assign sy0 = swap ? y1 : y0;
        assign sx1 = swap ? x0 : x1;
        assign sy1 = swap ? y0 : y1;
        assign dx  = sx1 - sx0;
        assign dy  = sy1 - sy0;
        assign ady = e_dy_reg[i][DB-1] ? DB'(-e_dy_reg[i]) : DB'(e_dy_reg[i]);
        assign cr  = CRB'(f_p1_reg[i]) - CRB'(f_p2_reg[i]);
        assign acr = cr[CRB-1] ? CRB'(-cr) : CRB'(cr);

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                e_box_reg[i]  <= !(qx > hix + tl || qx < lox - tl
                                   || qy > hiy + tl || qy < loy - tl);
                e_vert_reg[i] <= (dx < tl) || (dx == '0);
                e_vres_reg[i] <= (sy0 <= qy && qy <= sy1) || (sy1 <= qy && qy <= sy0);
                e_dx_reg[i]   <= dx;
                e_dy_reg[i]   <= dy;
                e_rx_reg[i]   <= qx - sx0;
                e_ry_reg[i]   <= qy - sy0;

                f_box_reg[i]   <= e_box_reg[i];
                f_vert_reg[i]  <= e_vert_reg[i];
                f_vres_reg[i]  <= e_vres_reg[i];
                f_steep_reg[i] <= ady > DB'(e_dx_reg[i]);
                f_p1_reg[i]    <= XB'(e_rx_reg[i]) * XB'(e_dy_reg[i]);
                f_p2_reg[i]    <= XB'(e_ry_reg[i]) * XB'(e_dx_reg[i]);
                f_tdy_reg[i]   <= TDB'(ctx_reg[4].tol) * TDB'(ady);
                f_tdx_reg[i]   <= TDB'(ctx_reg[4].tol) * TDB'(DB'(e_dx_reg[i]));
            end
        end

        assign chord_hit[i] = f_box_reg[i] && (f_vert_reg[i] ? f_vres_reg[i] :
                              (f_steep_reg[i] ? (acr <= CRB'(f_tdy_reg[i]))
                                              : (acr <= CRB'(f_tdx_reg[i]))));
    end

`ifndef SYNTH
    a_out_follows_pipe: assert property (@(posedge clk) disable iff (!rst_n)
        en |=> (out_valid == $past(vld_reg[5])))
        else $error("output valid does not follow last pipeline stage");

    a_stall_holds_pipe: assert property (@(posedge clk) disable iff (!rst_n)
        !en |=> ($stable(vld_reg) && $stable(hit)))
        else $error("pipeline moved during output stall");
`endif

endmodule

>>> tb/cubic_bezier_hit_test_top_tb.sv
// testbench for the cubic bezier hit test: directed and random requests checked in order
module cubic_bezier_hit_test_top_tb;
    timeunit 1ns;
    timeprecision 1ps;

    typedef logic signed [cbh_pkg::COORD_BITS-1:0] coord_t;

    typedef struct {
        coord_t px[4];
        coord_t py[4];
        coord_t qx;
        coord_t qy;
    } curve_req_t;

    logic clk;
    logic rst_n;
    logic cfg_wr_en;
    logic [cbh_pkg::TOL_BITS-1:0] cfg_wr_data;
    logic in_valid;
    logic in_ready;
    coord_t start_x, start_y, ctrl1_x, ctrl1_y, ctrl2_x, ctrl2_y, end_x, end_y;
    coord_t query_x, query_y;
    logic out_valid;
    logic out_ready;
    logic hit;

    logic [cbh_pkg::TOL_BITS-1:0] tol_shadow;
    logic expected_hits[$];
    int errors = 0;
    longint cycle_count;
    int stall_mode;

    cubic_bezier_hit_test_top dut (
        .clk(clk), .rst_n(rst_n),
        .cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data),
        .in_valid(in_valid), .in_ready(in_ready),
        .start_x(start_x), .start_y(start_y),
        .ctrl1_x(ctrl1_x), .ctrl1_y(ctrl1_y),
        .ctrl2_x(ctrl2_x), .ctrl2_y(ctrl2_y),
        .end_x(end_x), .end_y(end_y),
        .query_x(query_x), .query_y(query_y),
        .out_valid(out_valid), .out_ready(out_ready),
        .hit(hit)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    function automatic longint flat_coord(longint p0, longint p1, longint p2, longint p3,
                                          longint k);
        longint h;
        longint s;
        h = cbh_pkg::CURVE_STEPS - k;
        s = h * h * h * p0 + 3 * k * h * h * p1 + 3 * k * k * h * p2 + k * k * k * p3;
        return s / (longint'(cbh_pkg::CURVE_STEPS) * cbh_pkg::CURVE_STEPS
                    * cbh_pkg::CURVE_STEPS);
    endfunction

    function automatic longint mag(longint v);
        return v < 0 ? -v : v;
    endfunction

    function automatic bit chord_near(longint x0, longint y0, longint x1, longint y1,
                                      longint qx, longint qy, longint tol);
        longint lox, hix, loy, hiy, t, dx, dy, c;
        lox = x0 < x1 ? x0 : x1;
        hix = x0 < x1 ? x1 : x0;
        loy = y0 < y1 ? y0 : y1;
        hiy = y0 < y1 ? y1 : y0;
        if (qx > hix + tol || qx < lox - tol || qy > hiy + tol || qy < loy - tol)
            return 1'b0;
        if (x1 <= x0)
        begin
            t = x0; x0 = x1; x1 = t;
            t = y0; y0 = y1; y1 = t;
        end
        dx = x1 - x0;
        dy = y1 - y0;
        if (dx < tol || dx == 0)
            return (y0 <= qy && qy <= y1) || (y1 <= qy && qy <= y0);
        c = (qx - x0) * dy - (qy - y0) * dx;
        if (mag(dy) > dx)
            return mag(c) <= tol * mag(dy);
        return mag(c) <= tol * dx;
    endfunction

    function automatic logic predict_hit(curve_req_t r, logic [cbh_pkg::TOL_BITS-1:0] tol);
        longint xa, ya, xb, yb;
        xb = r.px[0];
        yb = r.py[0];
        for (int k = 0; k <= cbh_pkg::CURVE_STEPS; k++)
        begin
            xa = xb;
            ya = yb;
            xb = flat_coord(r.px[0], r.px[1], r.px[2], r.px[3], k);
            yb = flat_coord(r.py[0], r.py[1], r.py[2], r.py[3], k);
            if (chord_near(xa, ya, xb, yb, r.qx, r.qy, longint'(tol)))
                return 1'b1;
        end
        return 1'b0;
    endfunction

    // receiver stall pattern and result check
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_ready <= 1'b0;
            cycle_count <= 0;
            stall_mode <= 0;
        end
        else
        begin
            cycle_count <= cycle_count + 1;
            if (out_valid && out_ready)
            begin
                if (expected_hits.size() == 0)
                begin
                    $error("hit: unexpected result %0b", hit);
                    errors++;
                end
                else
                begin
                    logic e;
                    e = expected_hits.pop_front();
                    if (e !== hit)
                    begin
                        $error("hit: expected %0b actual %0b", e, hit);
                        errors++;
                    end
                end
            end
            case (stall_mode)
                0: out_ready <= 1'b1;
                1: out_ready <= ($urandom_range(0, 3) != 0);
                2: out_ready <= ((cycle_count % 7) < 3);
                default: out_ready <= ($urandom_range(0, 1) == 1);
            endcase
            if ((cycle_count % 300) == 0)
                stall_mode <= $urandom_range(0, 3);
        end
    end

    initial
    begin
        wait (rst_n === 1'b1);
        while (cycle_count < 5000000)
            @(posedge clk);
        $display("cubic_bezier_hit_test_top: mismatch");
        $finish;
    end

    task automatic send_curve(curve_req_t r);
        start_x <= r.px[0]; start_y <= r.py[0];
        ctrl1_x <= r.px[1]; ctrl1_y <= r.py[1];
        ctrl2_x <= r.px[2]; ctrl2_y <= r.py[2];
        end_x <= r.px[3]; end_y <= r.py[3];
        query_x <= r.qx; query_y <= r.qy;
        in_valid <= 1'b1;
        do
            @(posedge clk);
        while (!in_ready);
        expected_hits.push_back(predict_hit(r, tol_shadow));
    endtask

    // bursts with random gaps between them
    int burst_left;
    task automatic pace();
        int gap;
        if (burst_left > 0)
        begin
            burst_left--;
            return;
        end
        gap = $urandom_range(0, 4);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        burst_left = $urandom_range(0, 12);
    endtask

    task automatic wait_idle();
        while (expected_hits.size() != 0)
            @(posedge clk);
        repeat (12) @(posedge clk);
    endtask

    task automatic write_tolerance(logic [cbh_pkg::TOL_BITS-1:0] v);
        wait_idle();
        cfg_wr_en <= 1'b1;
        cfg_wr_data <= v;
        @(posedge clk);
        cfg_wr_en <= 1'b0;
        tol_shadow = v;
    endtask

    function automatic coord_t near_coord(coord_t base, int spread);
        return coord_t'(int'(base) + $signed($urandom_range(0, 2 * spread)) - spread);
    endfunction

    function automatic curve_req_t random_curve(int spread);
        curve_req_t r;
        coord_t cx, cy;
        int pick;
        cx = coord_t'($urandom);
        cy = coord_t'($urandom);
        for (int i = 0; i < 4; i++)
        begin
            r.px[i] = near_coord(cx, spread);
            r.py[i] = near_coord(cy, spread);
        end
        pick = $urandom_range(0, 9);
        if (pick < 7)
        begin
            // query near a sampled curve point
            int k;
            longint x, y;
            k = $urandom_range(0, cbh_pkg::CURVE_STEPS);
            x = flat_coord(r.px[0], r.px[1], r.px[2], r.px[3], k);
            y = flat_coord(r.py[0], r.py[1], r.py[2], r.py[3], k);
            r.qx = near_coord(coord_t'(x), 8);
            r.qy = near_coord(coord_t'(y), 8);
        end
        else if (pick < 9)
        begin
            r.qx = near_coord(cx, spread);
            r.qy = near_coord(cy, spread);
        end
        else
        begin
            r.qx = coord_t'($urandom);
            r.qy = coord_t'($urandom);
        end
        return r;
    endfunction

    function automatic curve_req_t line_curve(coord_t x0, coord_t y0, coord_t x1, coord_t y1,
                                              coord_t qx, coord_t qy);
        curve_req_t r;
        r.px[0] = x0; r.py[0] = y0; r.px[1] = x0; r.py[1] = y0;
        r.px[2] = x1; r.py[2] = y1; r.px[3] = x1; r.py[3] = y1;
        r.qx = qx; r.qy = qy;
        return r;
    endfunction

    task automatic test_directed();
        coord_t mx, mn;
        mx = 16'sh7fff;
        mn = -16'sh8000;
        send_curve(line_curve(mn, mn, mx, mx, 0, 0));
        send_curve(line_curve(mx, mx, mn, mn, mx, mn));
        send_curve(line_curve(mn, mx, mx, mn, mn, mx));
        send_curve(line_curve(0, 0, 0, 0, 0, 0));
        send_curve(line_curve(0, 0, 0, 0, 6, 0));
        send_curve(line_curve(10, 0, 12, 100, 11, 50));
        send_curve(line_curve(10, 0, 12, 100, 11, 120));
        send_curve(line_curve(0, 0, 100, 300, 38, 100));
        send_curve(line_curve(0, 0, 100, -300, 38, -100));
        send_curve(line_curve(0, 300, 100, 0, 62, 100));
        send_curve(line_curve(0, 0, 300, 100, 100, 38));
        send_curve(line_curve(0, 0, 300, -100, 100, -38));
        send_curve(line_curve(0, 0, 300, 100, 100, 45));
        send_curve(line_curve(100, 0, 0, 50, 50, 25));
        begin
            curve_req_t r;
            r.px = '{mx, mn, mx, mn};
            r.py = '{mn, mx, mn, mx};
            r.qx = mx; r.qy = mx;
            send_curve(r);
            r.px = '{-16'sd5, 16'sd3, -16'sd3, 16'sd5};
            r.py = '{16'sd0, 16'sd40, 16'sd40, 16'sd0};
            r.qx = 0; r.qy = 30;
            send_curve(r);
            r.qx = -1; r.qy = -1;
            send_curve(r);
        end
        in_valid <= 1'b0;
    endtask

    task automatic test_zero_tolerance();
        write_tolerance(8'd0);
        send_curve(line_curve(0, 0, 0, 0, 0, 0));
        send_curve(line_curve(0, 0, 0, 0, 1, 0));
        send_curve(line_curve(0, 0, 20, 20, 10, 10));
        send_curve(line_curve(5, 0, 5, 40, 5, 20));
        for (int i = 0; i < 150; i++)
        begin
            send_curve(random_curve($urandom_range(0, 1) ? 40 : 2000));
            pace();
        end
        in_valid <= 1'b0;
    endtask

    task automatic test_random_at(logic [cbh_pkg::TOL_BITS-1:0] tol, int count);
        write_tolerance(tol);
        for (int i = 0; i < count; i++)
        begin
            int spread;
            case ($urandom_range(0, 3))
                0: spread = 20;
                1: spread = 300;
                2: spread = 5000;
                default: spread = 32767;
            endcase
            send_curve(random_curve(spread));
            pace();
        end
        in_valid <= 1'b0;
    endtask

    initial
    begin
        rst_n = 1'b0;
        cfg_wr_en = 1'b0;
        cfg_wr_data = '0;
        in_valid = 1'b0;
        {start_x, start_y, ctrl1_x, ctrl1_y, ctrl2_x, ctrl2_y} = '0;
        {end_x, end_y, query_x, query_y} = '0;
        tol_shadow = cbh_pkg::TOL_RESET;
        burst_left = 0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed();
        test_random_at(cbh_pkg::TOL_RESET, 250);
        test_zero_tolerance();
        test_random_at(8'd255, 300);
        test_random_at(8'd1, 250);
        test_random_at(8'($urandom_range(2, 254)), 250);
        test_random_at(8'd5, 150);
        wait_idle();
        if (errors == 0)
            $display("cubic_bezier_hit_test_top: match");
        else
            $display("cubic_bezier_hit_test_top: mismatch");
        $finish;
    end
endmodule

>>> sim.f
rtl/cbh_pkg.sv
rtl/cubic_bezier_hit_test_top.sv
tb/cubic_bezier_hit_test_top_tb.sv
